[rtl/tcws_pkg.sv]
// Shared types and constants of the text console writer with scroll.
package tcws_pkg;

    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 50;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] ATTR_RESET   = 8'd15;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam int         PADDR_W       = 3;
    localparam logic [2:0] REG_ATTR_ADDR = 3'd0;

    typedef struct packed {
        logic        action;
        logic [7:0]  char_code;
        logic [11:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [11:0] cursor_pos;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear_step;
        logic scroll_start;
        logic copy_step;
        logic fill_step;
        logic put_step;
        logic emit_read;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic col_last;
        logic newline;
        logic copy_last;
        logic cell_last;
    } t_stat;

endpackage

[rtl/tcws_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tcws_ctrl.sv]
// Controller state machine: clearing pass, put, newline padding, scroll and read sequencing.
module tcws_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          i_action,
    input  tcws_pkg::t_stat i_stat,
    output tcws_pkg::t_cmd  o_cmd,
    output logic          busy,
    output logic          o_strobe
);
    import tcws_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_FLUSH = 3'd1;
    localparam logic [2:0] S_IDLE  = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_COPY  = 3'd4;
    localparam logic [2:0] S_FILL  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;
    localparam logic [2:0] S_RD    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_strobe = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.cell_last) begin
                    n_state = S_FLUSH;
                end
            end
            // The last clearing write lands here, before any read can be issued.
            S_FLUSH: begin
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_action == ACT_READ) ? S_RD : S_PUT;
                end
            end
            S_PUT: begin
                if (i_stat.full) begin
                    o_cmd.scroll_start = 1'b1;
                    n_state            = S_COPY;
                end else begin
                    o_cmd.put_step = 1'b1;
                    if (!i_stat.newline || i_stat.col_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_stat.copy_last) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.cell_last) begin
                    n_state = S_PUT;
                end
            end
            S_DONE: begin
                o_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_RD: begin
                o_cmd.emit_read = 1'b1;
                o_strobe        = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

[rtl/tcws_dp.sv]
// Datapath: cursor, sweep counter, delayed write stage and the screen memory.
module tcws_dp #(
    parameter int COLS = tcws_pkg::COLS_DEF,
    parameter int ROWS = tcws_pkg::ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcws_pkg::t_cmd     i_cmd,
    input  tcws_pkg::t_in_item i_item,
    input  logic [7:0]         i_attr,
    output tcws_pkg::t_stat    o_stat,
    output tcws_pkg::t_out_item o_result
);
    import tcws_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int LAST  = (ROWS - 1) * COLS;
    localparam int AW    = $clog2(CELLS + 1);
    localparam int RAW   = $clog2(CELLS);
    localparam int CLW   = $clog2(COLS);

    logic [AW-1:0]  r_cursor;
    logic [CLW-1:0] r_col;
    logic [AW-1:0]  r_k;
    logic [7:0]     r_char;
    logic           r_in_range;

    // Writes are issued in the cycle after they are scheduled, so that a copied
    // cell can come straight from the registered read data.
    logic           r_we;
    logic [RAW-1:0] r_waddr;
    logic           r_wsrc_ram;
    logic [15:0]    r_wdata;

    logic [RAW-1:0] raddr;
    logic [15:0]    rdata;
    logic [15:0]    wdata;
    logic [7:0]     put_char;

    assign put_char = (r_char == CHAR_NEWLINE) ? CHAR_SPACE : r_char;
    assign raddr    = i_cmd.copy_step ? RAW'(r_k + AW'(COLS)) : RAW'(i_item.cell_index);
    assign wdata    = r_wsrc_ram ? rdata : r_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_col    <= '0;
            r_k      <= '0;
            r_we     <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (i_cmd.clear_step || i_cmd.copy_step || i_cmd.fill_step) begin
                r_k <= r_k + AW'(1);
            end
            if (i_cmd.scroll_start) begin
                r_k <= '0;
            end
            if (i_cmd.clear_step || i_cmd.copy_step || i_cmd.fill_step) begin
                r_we    <= 1'b1;
                r_waddr <= r_k[RAW-1:0];
            end
            if (i_cmd.fill_step && o_stat.cell_last) begin
                r_cursor <= AW'(LAST);
                r_col    <= '0;
            end
            if (i_cmd.put_step) begin
                r_we     <= 1'b1;
                r_waddr  <= r_cursor[RAW-1:0];
                r_cursor <= r_cursor + AW'(1);
                r_col    <= o_stat.col_last ? '0 : r_col + CLW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wsrc_ram <= i_cmd.copy_step;
        if (i_cmd.clear_step) begin
            r_wdata <= '0;
        end else if (i_cmd.fill_step) begin
            r_wdata <= {i_attr, CHAR_SPACE};
        end else begin
            r_wdata <= {i_attr, put_char};
        end
        if (i_cmd.load) begin
            r_char     <= i_item.char_code;
            r_in_range <= 32'(i_item.cell_index) < 32'(CELLS);
        end
    end

    tcws_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_waddr(r_waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_stat.full      = (r_cursor == AW'(CELLS));
    assign o_stat.col_last  = (r_col == CLW'(COLS - 1));
    assign o_stat.newline   = (r_char == CHAR_NEWLINE);
    assign o_stat.copy_last = (r_k == AW'(LAST - 1));
    assign o_stat.cell_last = (r_k == AW'(CELLS - 1));

    assign o_result.cell_data  = (i_cmd.emit_read && r_in_range) ? rdata : 16'h0000;
    assign o_result.cursor_pos = 12'(r_cursor);

endmodule

[rtl/text_console_writer_with_scroll_unit.sv]
// Top level of the text console writer with scroll.
//
// A screen of ROWS x COLS 16-bit cells (attribute in the high byte, character
// in the low byte) with a write cursor. A word is taken on i_item when start is
// high and busy is low. A put writes the character at the cursor; a newline
// pads with spaces up to the next line start, at least one space. With the
// cursor past the last cell the screen first scrolls up one line and the new
// last line is filled with spaces. A read returns one cell.
// Every word gives one result word on o_result, valid for the single cycle in
// which o_strobe is high; the receiver cannot hold it off.
// Sequencing: a read gives its result in the cycle after acceptance, a plain
// put in the DONE state that follows the PUT state; busy falls in the cycle
// after the result, so the next word is taken only then. A newline stays in PUT
// for one put per padded cell. A scroll adds a start step, one copy per cell of
// the upper ROWS-1 lines, then one fill per cell of the last line.
// After reset the memory is cleared one cell per cycle while busy is high. The
// text attribute (reset 15) is written through the APB port at address 0; the
// user must write it only while idle; the block does not enforce this.
module text_console_writer_with_scroll_unit #(
    parameter int COLS = tcws_pkg::COLS_DEF,
    parameter int ROWS = tcws_pkg::ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  tcws_pkg::t_in_item           i_item,
    output logic                         o_strobe,
    output tcws_pkg::t_out_item          o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcws_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import tcws_pkg::*;

    logic [7:0] r_attr;
    t_cmd       cmd;
    t_stat      stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_ATTR_ADDR) begin
            r_attr <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_ATTR_ADDR) ? {24'h000000, r_attr} : 32'h00000000;

    tcws_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_action(i_item.action),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_strobe(o_strobe)
    );

    tcws_dp #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_item),
        .i_attr  (r_attr),
        .o_stat  (stat),
        .o_result(o_result)
    );

endmodule

[rtl/tcws_checker.sv]
// Port-level checks of the text console writer, bound to its top level.
module tcws_checker #(
    parameter int COLS = tcws_pkg::COLS_DEF,
    parameter int ROWS = tcws_pkg::ROWS_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_strobe,
    input tcws_pkg::t_out_item o_result,
    input logic                pready,
    input logic [31:0]         prdata
);
    import tcws_pkg::*;

    localparam int CELLS = ROWS * COLS;

    // Reset starts the clearing pass, so no word is taken right after it.
    a_busy_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // A result word is only shown while an accepted word is in progress.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (CELLS >= 4096) || (32'(o_result.cursor_pos) <= 32'(CELLS)))
        else $error("cursor beyond screen");

    a_prdata_attr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready |-> (prdata[31:8] == 24'h000000))
        else $error("register read wider than attribute");

endmodule

bind text_console_writer_with_scroll_unit tcws_checker #(
    .COLS(COLS),
    .ROWS(ROWS)
) u_tcws_checker (.*);
